[sv/mss_pkg.sv]
// shared types and codes for the multi-stack shared store
`timescale 1ns / 1ps
`default_nettype none

package mss_pkg;

    // payload widths fixed by the item format
    localparam int SIZE_W  = 7;
    localparam int INDEX_W = 3;
    localparam int WORD_W  = 32;

    typedef logic [1:0]         kind_t;
    typedef logic [1:0]         status_t;
    typedef logic [SIZE_W-1:0]  size_t;
    typedef logic [INDEX_W-1:0] index_t;
    typedef logic [WORD_W-1:0]  word_t;

    // operation codes
    localparam kind_t KIND_PUSH   = 2'd0;
    localparam kind_t KIND_POP    = 2'd1;
    localparam kind_t KIND_REINIT = 2'd2;

    // result codes
    localparam status_t STATUS_OK      = 2'd0;
    localparam status_t STATUS_FULL    = 2'd1;
    localparam status_t STATUS_EMPTY   = 2'd2;
    localparam status_t STATUS_INVALID = 2'd3;

endpackage

`default_nettype wire

[sv/mss_if.sv]
// command and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface mss_cmd_if;
    import mss_pkg::*;

    logic                valid;
    logic                ready;
    kind_t               kind;
    index_t              stack_index;
    logic signed [31:0]  value;

    modport source (output valid, kind, stack_index, value, input ready);
    modport sink   (input valid, kind, stack_index, value, output ready);
endinterface

interface mss_rsp_if;
    import mss_pkg::*;

    logic     valid;
    logic     ready;
    status_t  status;
    size_t    stack_size;
    size_t    total_size;

    modport source (output valid, status, stack_size, total_size, input ready);
    modport sink   (input valid, status, stack_size, total_size, output ready);
endinterface

`default_nettype wire

[sv/multi_stack_shared_store_top.sv]
// several stacks sharing one word memory, with on-demand right shifting
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+-------------------------------------
//  cmd     | in  | valid / ready | kind, stack_index, value
//  rsp     | out | valid / ready | status, stack_size, total_size
//
// push, pop and reinit are accepted in the idle state; the execute state then reads and
// updates the per-stack base and count registers and, on a push, writes the word memory.
// a push to a full stack scans stacks from the highest down, and a stack that moves
// shifts its words up one place through the memory's separate read and write ports
// (read and write overlap); then the push state places the new word.
// reset restores the bases to their initial slices and clears counts and control at once;
// the word memory is not cleared. a stalled rsp holds its item; the next cmd item is still
// taken and waits in its execute or push step until the response register is free.
`timescale 1ns / 1ps
`default_nettype none

module multi_stack_shared_store_top #(
    parameter int CAPACITY = 64,
    parameter int STACKS   = 4
) (
    input  wire       clk,
    input  wire       rst_n,
    mss_cmd_if.sink   cmd,
    mss_rsp_if.source rsp
);
    import mss_pkg::*;

    localparam int AW    = $clog2(CAPACITY);
    localparam int BW    = $clog2(CAPACITY + 1);
    localparam int SW    = $clog2(STACKS);
    localparam int SLICE = CAPACITY / STACKS;
    localparam logic [SW-1:0] LAST_IDX = SW'(STACKS - 1);
    localparam logic [BW-1:0] CAP_B    = BW'(CAPACITY);

    // sequencer codes
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_MOVE = 3'd3;
    localparam logic [2:0] ST_PUSH = 3'd4;

    logic [2:0]    state_reg, state_next;

    // latched item
    kind_t         kind_reg;
    logic [SW-1:0] sidx_reg;
    logic          sok_reg;
    word_t         value_reg;

    // per-stack control state
    logic [BW-1:0] base_reg  [STACKS];
    logic [BW-1:0] count_reg [STACKS];
    logic [BW-1:0] total_reg, total_next;
    logic [STACKS-1:0] gap;

    // shift sequencing
    logic [SW-1:0] j_reg, j_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0] wr_addr_reg, wr_addr_next;
    logic [BW-1:0] left_reg, left_next;
    logic          pend_reg, pend_next;

    // word memory
    word_t         mem [CAPACITY];
    word_t         rdata_reg;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    word_t         mem_wdata;

    // selected stack view
    logic [SW-1:0] sel_idx;
    logic [BW-1:0] sel_base, sel_count;
    logic          sel_gap;
    logic [AW-1:0] sel_top;

    // update controls
    logic          cnt_we, base_inc, reinit;
    logic [BW-1:0] cnt_wdata;
    logic          res_fire, out_free;
    status_t       res_status;
    logic [BW-1:0] res_size, res_total;

    logic          out_valid_reg;
    status_t       out_status_reg;
    size_t         out_size_reg, out_total_reg;

    // room test for each stack against the base above it, or the store's end for the highest
    genvar g;
    generate
        for (g = 0; g < STACKS; g++) begin : g_gap
            logic [BW-1:0] above;
            if (g < STACKS - 1) begin : g_mid
                assign above = base_reg[g+1];
            end else begin : g_last
                assign above = CAP_B;
            end
            assign gap[g] = ({1'b0, base_reg[g]} + {1'b0, count_reg[g]}) < {1'b0, above};
        end
    endgenerate

    // one stack is looked at per cycle
    assign sel_idx   = (state_reg == ST_SCAN || state_reg == ST_MOVE) ? j_reg : sidx_reg;
    assign sel_base  = base_reg[sel_idx];
    assign sel_count = count_reg[sel_idx];
    assign sel_gap   = gap[sel_idx];
    assign sel_top   = AW'(sel_base + sel_count);

    assign out_free  = !out_valid_reg || rsp.ready;
    assign cmd.ready = (state_reg == ST_IDLE);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        j_next       = j_reg;
        rd_ptr_next  = rd_ptr_reg;
        wr_addr_next = wr_addr_reg;
        left_next    = left_reg;
        pend_next    = pend_reg;
        total_next   = total_reg;
        cnt_we       = 1'b0;
        cnt_wdata    = sel_count;
        base_inc     = 1'b0;
        reinit       = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = sel_top;
        mem_wdata    = value_reg;
        mem_re       = 1'b0;
        mem_raddr    = rd_ptr_reg;
        res_fire     = 1'b0;
        res_status   = STATUS_OK;
        res_size     = sel_count;
        res_total    = total_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                if (kind_reg == KIND_REINIT)
                begin
                    res_fire  = 1'b1;
                    res_size  = '0;
                    res_total = '0;
                    reinit    = out_free;
                    total_next = out_free ? '0 : total_reg;
                end
                else if (!sok_reg)
                begin
                    res_fire   = 1'b1;
                    res_status = STATUS_INVALID;
                    res_size   = '0;
                end
                else if (kind_reg == KIND_PUSH)
                begin
                    if (sel_gap)
                    begin
                        res_fire  = 1'b1;
                        res_size  = sel_count + 1'b1;
                        res_total = total_reg + 1'b1;
                        if (out_free)
                        begin
                            mem_we     = 1'b1;
                            cnt_we     = 1'b1;
                            cnt_wdata  = sel_count + 1'b1;
                            total_next = total_reg + 1'b1;
                        end
                    end
                    else if (sidx_reg == LAST_IDX)
                    begin
                        res_fire   = 1'b1;
                        res_status = STATUS_FULL;
                    end
                    else
                    begin
                        j_next     = LAST_IDX;
                        state_next = ST_SCAN;
                    end
                end
                else if (kind_reg == KIND_POP)
                begin
                    res_fire = 1'b1;
                    if (sel_count == '0)
                    begin
                        res_status = STATUS_EMPTY;
                    end
                    else
                    begin
                        res_size  = sel_count - 1'b1;
                        res_total = total_reg - 1'b1;
                        if (out_free)
                        begin
                            cnt_we     = 1'b1;
                            cnt_wdata  = sel_count - 1'b1;
                            total_next = total_reg - 1'b1;
                        end
                    end
                end
                else
                begin
                    res_fire = 1'b1;
                end
                if (res_fire && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                if (sel_gap && sel_count != '0)
                begin
                    rd_ptr_next = AW'(sel_base + sel_count - 1'b1);
                    left_next   = sel_count;
                    pend_next   = 1'b0;
                    state_next  = ST_MOVE;
                end
                else
                begin
                    base_inc = sel_gap;
                    if (SW'(j_reg - 1'b1) == sidx_reg)
                    begin
                        state_next = ST_PUSH;
                    end
                    else
                    begin
                        j_next = SW'(j_reg - 1'b1);
                    end
                end
            end

            ST_MOVE:
            begin
                // read the next lower word while writing the previous one up
                mem_re = (left_reg != '0);
                if (mem_re)
                begin
                    rd_ptr_next  = rd_ptr_reg - 1'b1;
                    wr_addr_next = rd_ptr_reg + 1'b1;
                    left_next    = left_reg - 1'b1;
                end
                pend_next = mem_re;
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wr_addr_reg;
                    mem_wdata = rdata_reg;
                end
                if (!mem_re && !pend_reg)
                begin
                    base_inc = 1'b1;
                    if (SW'(j_reg - 1'b1) == sidx_reg)
                    begin
                        state_next = ST_PUSH;
                    end
                    else
                    begin
                        j_next     = SW'(j_reg - 1'b1);
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_PUSH:
            begin
                res_fire = 1'b1;
                if (sel_gap)
                begin
                    res_size  = sel_count + 1'b1;
                    res_total = total_reg + 1'b1;
                    if (out_free)
                    begin
                        mem_we     = 1'b1;
                        cnt_we     = 1'b1;
                        cnt_wdata  = sel_count + 1'b1;
                        total_next = total_reg + 1'b1;
                    end
                end
                else
                begin
                    res_status = STATUS_FULL;
                end
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers and per-stack state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            j_reg       <= '0;
            rd_ptr_reg  <= '0;
            wr_addr_reg <= '0;
            left_reg    <= '0;
            pend_reg    <= 1'b0;
            total_reg   <= '0;
            for (int i = 0; i < STACKS; i++)
            begin
                base_reg[i]  <= BW'(i * SLICE);
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            j_reg       <= j_next;
            rd_ptr_reg  <= rd_ptr_next;
            wr_addr_reg <= wr_addr_next;
            left_reg    <= left_next;
            pend_reg    <= pend_next;
            total_reg   <= total_next;
            if (reinit)
            begin
                for (int i = 0; i < STACKS; i++)
                begin
                    base_reg[i]  <= BW'(i * SLICE);
                    count_reg[i] <= '0;
                end
            end
            else
            begin
                if (cnt_we)
                begin
                    count_reg[sel_idx] <= cnt_wdata;
                end
                if (base_inc)
                begin
                    base_reg[sel_idx] <= sel_base + 1'b1;
                end
            end
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            kind_reg  <= cmd.kind;
            sidx_reg  <= SW'(cmd.stack_index);
            sok_reg   <= (32'(cmd.stack_index) < 32'(STACKS));
            value_reg <= word_t'(cmd.value);
        end
    end

    // word memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_fire && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_fire && out_free)
        begin
            out_status_reg <= res_status;
            out_size_reg   <= SIZE_W'(res_size);
            out_total_reg  <= SIZE_W'(res_total);
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.stack_size = out_size_reg;
    assign rsp.total_size = out_total_reg;

endmodule

`default_nettype wire

[sv/mss_checker.sv]
// port-level checks for the multi-stack shared store, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module mss_checker #(
    parameter int CAPACITY = 64
) (
    input wire                   clk,
    input wire                   rst_n,
    input wire                   rsp_valid,
    input wire                   rsp_ready,
    input wire mss_pkg::status_t status,
    input wire mss_pkg::size_t   stack_size,
    input wire mss_pkg::size_t   total_size
);
    import mss_pkg::*;

    localparam bit SIZES_FIT = (CAPACITY < 128);

    // a stalled response item stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // invalid and empty results report an empty addressed stack
    a_zero_size: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == STATUS_INVALID || status == STATUS_EMPTY)
        |-> stack_size == '0)
        else $error("nonzero stack size on invalid or empty result");

    // one stack never holds more than all stacks together
    a_part_of_total: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && SIZES_FIT |-> stack_size <= total_size)
        else $error("stack size exceeds total size");

    // the store never holds more words than it has
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && SIZES_FIT |-> 32'(total_size) <= 32'(CAPACITY))
        else $error("total size exceeds capacity");

endmodule

bind multi_stack_shared_store_top mss_checker #(.CAPACITY(CAPACITY)) u_mss_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .status     (rsp.status),
    .stack_size (rsp.stack_size),
    .total_size (rsp.total_size)
);

`default_nettype wire

[tb/sv/tb_top.sv]
// self-checking testbench for the multi-stack shared store
`timescale 1ns / 1ps

module tb_top;
    import mss_pkg::*;

    localparam int CAPACITY   = 64;
    localparam int STACKS     = 4;
    localparam int RAND_ITEMS = 1800;
    localparam int TAIL_WAIT  = 300;

    typedef struct packed {
        status_t status;
        size_t   stack_size;
        size_t   total_size;
    } outcome_t;

    typedef struct packed {
        kind_t   kind;
        index_t  idx;
        word_t   value;
        logic    typed;
        status_t status;
        size_t   stack_size;
        size_t   total_size;
    } script_row_t;

    typedef enum int {MODE_FILL, MODE_MIXED, MODE_DRAIN, MODE_NOISE} traffic_e;

    logic clk = 1'b0;
    logic rst_n;
    logic gaps_on;
    int   err_count;

    // predictor state: per-stack base and fill level
    size_t stack_base [STACKS];
    size_t stack_fill [STACKS];

    outcome_t pending_outcomes [$];

    mss_cmd_if cmd_ch ();
    mss_rsp_if rsp_ch ();

    multi_stack_shared_store_top #(
        .CAPACITY (CAPACITY),
        .STACKS   (STACKS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // directed items: expectations typed in only where obvious
    script_row_t script [0:19] = '{
        '{KIND_POP,    3'd0, 32'h0000_0000, 1'b1, STATUS_EMPTY,   7'd0, 7'd0},
        '{KIND_PUSH,   3'd0, 32'h7FFF_FFFF, 1'b1, STATUS_OK,      7'd1, 7'd1},
        '{KIND_PUSH,   3'd0, 32'h8000_0000, 1'b1, STATUS_OK,      7'd2, 7'd2},
        '{KIND_PUSH,   3'd3, 32'h0000_0000, 1'b1, STATUS_OK,      7'd1, 7'd3},
        '{KIND_PUSH,   3'd4, 32'hFFFF_FFFF, 1'b1, STATUS_INVALID, 7'd0, 7'd3},
        '{KIND_POP,    3'd7, 32'h0000_0000, 1'b1, STATUS_INVALID, 7'd0, 7'd3},
        '{KIND_PUSH,   3'd7, 32'h0000_0001, 1'b1, STATUS_INVALID, 7'd0, 7'd3},
        '{KIND_POP,    3'd0, 32'h0000_0000, 1'b1, STATUS_OK,      7'd1, 7'd2},
        '{KIND_POP,    3'd0, 32'h0000_0000, 1'b1, STATUS_OK,      7'd0, 7'd1},
        '{KIND_POP,    3'd0, 32'h0000_0000, 1'b1, STATUS_EMPTY,   7'd0, 7'd1},
        '{KIND_PUSH,   3'd1, 32'hFFFF_FFFF, 1'b0, STATUS_OK,      7'd0, 7'd0},
        '{KIND_PUSH,   3'd2, 32'h0000_0001, 1'b0, STATUS_OK,      7'd0, 7'd0},
        '{KIND_POP,    3'd3, 32'h0000_0000, 1'b0, STATUS_OK,      7'd0, 7'd0},
        '{KIND_POP,    3'd3, 32'h0000_0000, 1'b0, STATUS_OK,      7'd0, 7'd0},
        '{KIND_REINIT, 3'd7, 32'hDEAD_BEEF, 1'b1, STATUS_OK,      7'd0, 7'd0},
        '{KIND_POP,    3'd2, 32'h0000_0000, 1'b1, STATUS_EMPTY,   7'd0, 7'd0},
        '{KIND_PUSH,   3'd2, 32'hAAAA_AAAA, 1'b1, STATUS_OK,      7'd1, 7'd1},
        '{KIND_REINIT, 3'd0, 32'h0000_0000, 1'b1, STATUS_OK,      7'd0, 7'd0},
        '{KIND_PUSH,   3'd3, 32'h5555_5555, 1'b1, STATUS_OK,      7'd1, 7'd1},
        '{KIND_POP,    3'd3, 32'h0000_0000, 1'b1, STATUS_OK,      7'd0, 7'd0}
    };

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // base of the next stack up, or the end of the store for the highest one
    function automatic int room_limit(int s);
        return (s + 1 < STACKS) ? int'(stack_base[s + 1]) : CAPACITY;
    endfunction

    function automatic bit is_full(int s);
        return int'(stack_base[s]) + int'(stack_fill[s]) >= room_limit(s);
    endfunction

    function automatic void clear_stacks();
        int i;
        for (i = 0; i < STACKS; i++)
        begin
            stack_base[i] = size_t'(i * (CAPACITY / STACKS));
            stack_fill[i] = '0;
        end
    endfunction

    // apply one command to the predictor and return the response it gives
    function automatic outcome_t stack_outcome(kind_t k, index_t idx);
        outcome_t o;
        int       s;
        int       j;
        int       total;
        o.status     = STATUS_OK;
        o.stack_size = '0;
        s            = int'(idx);
        if (k == KIND_REINIT)
        begin
            clear_stacks();
        end
        else if (s >= STACKS)
        begin
            o.status = STATUS_INVALID;
        end
        else if (k == KIND_PUSH)
        begin
            // make room by sliding higher stacks up, highest first
            if (is_full(s))
            begin
                for (j = STACKS - 1; j > s; j--)
                begin
                    if (!is_full(j))
                        stack_base[j] = stack_base[j] + 1'b1;
                end
            end
            if (is_full(s))
                o.status = STATUS_FULL;
            else
                stack_fill[s] = stack_fill[s] + 1'b1;
            o.stack_size = stack_fill[s];
        end
        else if (k == KIND_POP)
        begin
            if (stack_fill[s] == 0)
                o.status = STATUS_EMPTY;
            else
                stack_fill[s] = stack_fill[s] - 1'b1;
            o.stack_size = stack_fill[s];
        end
        else
        begin
            o.stack_size = stack_fill[s];
        end
        total = 0;
        for (j = 0; j < STACKS; j++)
            total += int'(stack_fill[j]);
        o.total_size = size_t'(total);
        return o;
    endfunction

    // drive one item, wait for acceptance, record the expected response
    task automatic send_item(kind_t k, index_t idx, word_t val, bit typed, outcome_t typed_rsp);
        outcome_t predicted;
        @(negedge clk);
        while (gaps_on && $urandom_range(99) < 35)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.kind        <= k;
        cmd_ch.stack_index <= idx;
        cmd_ch.value       <= val;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        predicted = stack_outcome(k, idx);
        pending_outcomes.push_back(typed ? typed_rsp : predicted);
    endtask

    // response ready with random stalls
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= !(gaps_on && $urandom_range(99) < 35);
        end
    end

    // response checker
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: unexpected item: status %0d stack_size %0d total_size %0d",
                         $time, rsp_ch.status, rsp_ch.stack_size, rsp_ch.total_size);
                err_count++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (rsp_ch.status !== want.status)
                begin
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, want.status, rsp_ch.status);
                    err_count++;
                end
                if (rsp_ch.stack_size !== want.stack_size)
                begin
                    $display("%0t: stack_size mismatch: expected %0d, got %0d",
                             $time, want.stack_size, rsp_ch.stack_size);
                    err_count++;
                end
                if (rsp_ch.total_size !== want.total_size)
                begin
                    $display("%0t: total_size mismatch: expected %0d, got %0d",
                             $time, want.total_size, rsp_ch.total_size);
                    err_count++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        int       n;
        int       r;
        int       burst_left;
        traffic_e mode;
        index_t   focus;
        kind_t    k;
        index_t   idx;
        word_t    val;

        err_count          = 0;
        gaps_on            = 1'b1;
        rst_n              = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.kind        = KIND_PUSH;
        cmd_ch.stack_index = '0;
        cmd_ch.value       = '0;
        clear_stacks();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        for (n = 0; n < 20; n++)
        begin
            send_item(script[n].kind, script[n].idx, script[n].value, script[n].typed,
                      '{script[n].status, script[n].stack_size, script[n].total_size});
        end

        // random bursts of related traffic
        burst_left = 0;
        mode       = MODE_FILL;
        focus      = '0;
        for (n = 0; n < RAND_ITEMS; n++)
        begin
            // a long stretch with no idling on either side
            gaps_on = !(n >= 700 && n < 1000);
            if (burst_left == 0)
            begin
                mode       = traffic_e'($urandom_range(3));
                burst_left = $urandom_range(40, 8);
                focus      = ($urandom_range(1) == 0) ? index_t'(STACKS - 1)
                                                      : index_t'($urandom_range(STACKS - 1));
                if ($urandom_range(9) == 0)
                    send_item(KIND_REINIT, index_t'($urandom_range(7)), $urandom, 1'b0, '0);
            end
            burst_left--;
            r = $urandom_range(99);
            case (mode)
                MODE_FILL:
                begin
                    k   = (r < 90) ? KIND_PUSH : KIND_POP;
                    idx = focus;
                end
                MODE_MIXED:
                begin
                    k   = (r < 65) ? KIND_PUSH : KIND_POP;
                    idx = index_t'($urandom_range(STACKS - 1));
                end
                MODE_DRAIN:
                begin
                    k   = (r < 75) ? KIND_POP : KIND_PUSH;
                    idx = index_t'($urandom_range(STACKS - 1));
                end
                default:
                begin
                    k   = kind_t'($urandom_range(2));
                    idx = index_t'($urandom_range(7));
                end
            endcase
            case ($urandom_range(19))
                0:       val = 32'h7FFF_FFFF;
                1:       val = 32'h8000_0000;
                2:       val = 32'hFFFF_FFFF;
                3:       val = 32'h0000_0000;
                default: val = $urandom;
            endcase
            send_item(k, idx, val, 1'b0, '0);
        end

        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        gaps_on = 1'b1;

        // drain outstanding responses, then let any trailing activity settle
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
        if (pending_outcomes.size() != 0)
        begin
            $display("%0t: %0d expected items never arrived", $time, pending_outcomes.size());
            err_count++;
        end

        if (err_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #4_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule

[sim.f]
sv/mss_pkg.sv
sv/mss_if.sv
sv/multi_stack_shared_store_top.sv
sv/mss_checker.sv
tb/sv/tb_top.sv
